FILE: hdl/cpg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Critical point gap tracker package
// Shared widths, limits and types for the front end, queue and back end.
// ----------------------------------------------------------------------------
package cpg_pkg;

  localparam int SAMPLE_W        = 16;
  localparam int GAP_W           = 16;
  localparam logic [GAP_W-1:0] GAP_LIMIT = {GAP_W{1'b1}};
  localparam int MAX_LEN_DEFAULT = 65535;
  localparam int QUEUE_DEPTH     = 4;

  // How many critical points the back end has seen, saturating at two.
  typedef enum logic [1:0] {
    SEEN_NONE = 2'd0,
    SEEN_ONE  = 2'd1,
    SEEN_TWO  = 2'd2
  } cpg_seen_t;

  // Classification that the front end attaches to each queued word.
  typedef struct packed {
    logic critical;
    logic last;
  } cpg_flags_t;

  localparam int FLAGS_W = $bits(cpg_flags_t);

endpackage

FILE: hdl/cpg_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sample channel
// Valid/ready channel that carries one sample word and its last flag.
// ----------------------------------------------------------------------------
interface cpg_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] sample;
  logic        last;

  modport source (output valid, output sample, output last, input ready);
  modport sink (input valid, input sample, input last, output ready);
endinterface

FILE: hdl/cpg_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel that carries one gap result word.
// ----------------------------------------------------------------------------
interface cpg_out_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic [15:0] min_gap;
  logic [15:0] max_gap;

  modport source (output valid, output found, output min_gap, output max_gap, input ready);
  modport sink (input valid, input found, input min_gap, input max_gap, output ready);
endinterface

FILE: hdl/cpg_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Critical point gap tracker front end
// Accepts samples, classifies the middle sample and queues the verdict.
// ----------------------------------------------------------------------------
module cpg_front #(
  parameter int MAX_LEN = cpg_pkg::MAX_LEN_DEFAULT,
  parameter int POS_W   = $clog2(MAX_LEN + 1)
) (
  input  logic                clk,
  input  logic                rst,
  cpg_in_if.sink              samples,
  input  logic                queue_full,
  output logic                push,
  output cpg_pkg::cpg_flags_t push_flags,
  output logic [POS_W-1:0]    push_pos
);
  import cpg_pkg::*;

  localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_LEN);

  logic [SAMPLE_W-1:0] older_sample;
  logic [SAMPLE_W-1:0] middle_sample;
  logic [POS_W-1:0]    position;
  logic                take;
  logic                peak;
  logic                valley;
  logic                critical;

  assign samples.ready = !queue_full;
  assign take          = samples.valid && samples.ready;

  assign peak     = (middle_sample > older_sample) && (middle_sample > samples.sample);
  assign valley   = (middle_sample < older_sample) && (middle_sample < samples.sample);
  assign critical = (position >= POS_W'(2)) && (peak || valley);

  assign push                = take && (critical || samples.last);
  assign push_flags.critical = critical;
  assign push_flags.last     = samples.last;
  assign push_pos            = position - POS_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      older_sample  <= '0;
      middle_sample <= '0;
      position      <= '0;
    end else if (take) begin
      if (samples.last) begin
        older_sample  <= '0;
        middle_sample <= '0;
        position      <= '0;
      end else begin
        older_sample  <= middle_sample;
        middle_sample <= samples.sample;
        if (position < POS_MAX) begin
          position <= position + POS_W'(1);
        end
      end
    end
  end

endmodule

FILE: hdl/cpg_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Critical point gap tracker queue
// Small first-in first-out buffer between the front end and the back end.
// ----------------------------------------------------------------------------
module cpg_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = cpg_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);
  import cpg_pkg::*;

  // DEPTH is a power of two so the pointers wrap on their own.
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] entries [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [AW:0]      count;
  logic             do_push;
  logic             do_pop;

  assign full     = (count == (AW+1)'(DEPTH));
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + AW'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + (AW+1)'(1);
        2'b01:   count <= count - (AW+1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: hdl/cpg_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Critical point gap tracker back end
// Tracks first, latest and closest critical points and builds the result.
// ----------------------------------------------------------------------------
module cpg_back #(
  parameter int MAX_LEN = cpg_pkg::MAX_LEN_DEFAULT,
  parameter int POS_W   = $clog2(MAX_LEN + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                queue_empty,
  input  cpg_pkg::cpg_flags_t head_flags,
  input  logic [POS_W-1:0]    head_pos,
  output logic                pop,
  cpg_out_if.source           results
);
  import cpg_pkg::*;

  localparam int EXT_W = (POS_W > GAP_W) ? POS_W : GAP_W + 1;

  logic [POS_W-1:0] first_critical;
  logic [POS_W-1:0] latest_critical;
  logic [GAP_W-1:0] smallest_gap;
  cpg_seen_t        critical_seen;

  logic [POS_W-1:0] first_critical_next;
  logic [POS_W-1:0] latest_critical_next;
  logic [GAP_W-1:0] smallest_gap_next;
  cpg_seen_t        critical_seen_next;

  logic [EXT_W-1:0] step_gap;
  logic [GAP_W-1:0] step_gap_sat;
  logic [EXT_W-1:0] span;
  logic [GAP_W-1:0] span_sat;
  logic             out_free;

  assign out_free = !results.valid || results.ready;
  // A last word must wait for room in the output register; others never stall.
  assign pop      = !queue_empty && (!head_flags.last || out_free);

  assign step_gap     = EXT_W'(head_pos) - EXT_W'(latest_critical);
  assign step_gap_sat = (step_gap > EXT_W'(GAP_LIMIT)) ? GAP_LIMIT : step_gap[GAP_W-1:0];

  always_comb begin
    first_critical_next  = first_critical;
    latest_critical_next = latest_critical;
    smallest_gap_next    = smallest_gap;
    critical_seen_next   = critical_seen;
    if (head_flags.critical) begin
      latest_critical_next = head_pos;
      if (critical_seen == SEEN_NONE) begin
        first_critical_next = head_pos;
        critical_seen_next  = SEEN_ONE;
      end else begin
        critical_seen_next = SEEN_TWO;
        if (step_gap_sat < smallest_gap) begin
          smallest_gap_next = step_gap_sat;
        end
      end
    end
  end

  assign span     = EXT_W'(latest_critical_next) - EXT_W'(first_critical_next);
  assign span_sat = (span > EXT_W'(GAP_LIMIT)) ? GAP_LIMIT : span[GAP_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      first_critical  <= '0;
      latest_critical <= '0;
      smallest_gap    <= GAP_LIMIT;
      critical_seen   <= SEEN_NONE;
    end else if (pop) begin
      if (head_flags.last) begin
        first_critical  <= '0;
        latest_critical <= '0;
        smallest_gap    <= GAP_LIMIT;
        critical_seen   <= SEEN_NONE;
      end else begin
        first_critical  <= first_critical_next;
        latest_critical <= latest_critical_next;
        smallest_gap    <= smallest_gap_next;
        critical_seen   <= critical_seen_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (pop && head_flags.last) begin
      results.valid <= 1'b1;
    end else if (results.ready) begin
      results.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head_flags.last) begin
      if (critical_seen_next == SEEN_TWO) begin
        results.found   <= 1'b1;
        results.min_gap <= smallest_gap_next;
        results.max_gap <= span_sat;
      end else begin
        results.found   <= 1'b0;
        results.min_gap <= '0;
        results.max_gap <= '0;
      end
    end
  end

endmodule

FILE: hdl/critical_point_gap_tracker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Critical point gap tracker
// Finds peaks and valleys in a sample stream and reports the smallest gap
// between neighboring critical points and the span from first to latest.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Word contents
//   -------   ---------  -------------------------------------------
//   samples   in         sample[15:0], last
//   results   out        found, min_gap[15:0], max_gap[15:0]
//
// One sample word is taken every cycle while the queue has room; a result
// is registered when its last word is popped from the queue head; that pop
// waits while the output register holds a result not yet taken. The front
// end classifies each sample combinationally. Reset (rst, synchronous)
// clears the sample history, position counter, queue and gap trackers; no
// clearing pass is needed. A stalled result channel only holds back a last
// word at the queue head, so samples keep flowing until the queue fills.
//
module critical_point_gap_tracker #(
  parameter int MAX_LEN = cpg_pkg::MAX_LEN_DEFAULT
) (
  input  logic      clk,
  input  logic      rst,
  cpg_in_if.sink    samples,
  cpg_out_if.source results
);
  import cpg_pkg::*;

  // The position counter must hold MAX_LEN itself, since it saturates there.
  localparam int POS_W   = $clog2(MAX_LEN + 1);
  localparam int ENTRY_W = FLAGS_W + POS_W;

  logic               push;
  cpg_flags_t         push_flags;
  logic [POS_W-1:0]   push_pos;
  logic               queue_full;
  logic               queue_empty;
  logic               pop;
  logic [ENTRY_W-1:0] head_entry;
  cpg_flags_t         head_flags;
  logic [POS_W-1:0]   head_pos;

  // The front end classifies each sample as it arrives; only words that carry
  // a critical point or close a sequence are queued.
  cpg_front #(
    .MAX_LEN (MAX_LEN),
    .POS_W   (POS_W)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .samples    (samples),
    .queue_full (queue_full),
    .push       (push),
    .push_flags (push_flags),
    .push_pos   (push_pos)
  );

  cpg_queue #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data ({push_flags, push_pos}),
    .full      (queue_full),
    .pop       (pop),
    .pop_data  (head_entry),
    .empty     (queue_empty)
  );

  assign head_flags = cpg_flags_t'(head_entry[ENTRY_W-1:POS_W]);
  assign head_pos   = head_entry[POS_W-1:0];

  // The back end folds critical positions into the running gap figures and
  // writes the result word when a sequence closes.
  cpg_back #(
    .MAX_LEN (MAX_LEN),
    .POS_W   (POS_W)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .queue_empty (queue_empty),
    .head_flags  (head_flags),
    .head_pos    (head_pos),
    .pop         (pop),
    .results     (results)
  );

endmodule
